[sv/mrrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the CRC-16/MODBUS bit step for the read-reply
// checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  localparam int BUFFER_BYTES_DEF = 32;
  localparam int MAX_REGS_DEF     = 16;
  localparam int RESULT_LIMIT     = 13;
  localparam int MIN_FRAME        = 5;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;

  // configuration register indexes
  localparam logic REG_SLAVE_ADDR = 1'b0;
  localparam logic REG_QUANTITY   = 1'b1;

  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } crc_ctl_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c);
    crc_step = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

[sv/mrrc_ram.sv]
// ----------------------------------------------------------------------------
// mrrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/mrrc_crc.sv]
// ----------------------------------------------------------------------------
// mrrc_crc
// Bit-serial CRC-16/MODBUS: a byte is folded in bit by bit, one
// polynomial step per cycle.
// ----------------------------------------------------------------------------
module mrrc_crc (
  input  logic                clk,
  input  logic                rst,
  input  mrrc_pkg::crc_ctl_t  ctl,
  output logic [15:0]         crc,
  output logic                busy
);
  import mrrc_pkg::*;

  logic [2:0] steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= CRC_INIT;
      busy  <= 1'b0;
      steps <= '0;
    end else if (ctl.clear) begin
      crc   <= CRC_INIT;
      busy  <= 1'b0;
      steps <= '0;
    end else if (ctl.feed) begin
      // xor in the byte and take the first step at once
      crc   <= crc_step(crc ^ {8'h00, ctl.data});
      busy  <= 1'b1;
      steps <= 3'd1;
    end else if (busy) begin
      crc   <= crc_step(crc);
      steps <= steps + 3'd1;
      if (steps == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/modbus_read_response_checker_core.sv]
// ----------------------------------------------------------------------------
// modbus_read_response_checker_core
// Checks one function 0x03 reply byte by byte and streams out its registers,
// or a single failure result, when the frame is closed.
// ----------------------------------------------------------------------------
// Data byte: from the third stored byte on, busy stays high after the transfer
//   while the bit-serial CRC takes one bit per cycle.
// Frame close: a failure result follows in the next cycle; register results
//   start once ST_EMIT is entered (registered read), one per cycle, q in all. start is
//   taken again in the cycle of the last result; results cannot be stalled.
// Reset clears counters, frame state and config (address 1, quantity 1), not the RAM.
module modbus_read_response_checker_core #(
  parameter int BUFFER_BYTES = mrrc_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_REGS     = mrrc_pkg::MAX_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic        frame_ok,
  output logic [3:0]  reg_index,
  output logic [15:0] reg_value,
  output logic        last_of_frame,
  output logic [31:0] ok_total,
  output logic [31:0] fail_total,
  output logic [7:0]  consec_fail,
  output logic [7:0]  max_consec_fail
);
  import mrrc_pkg::*;

  localparam int CW  = $clog2(BUFFER_BYTES + 1);
  localparam int RAW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int IW  = ((CW > RAW) ? CW : RAW) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t      state;
  logic [7:0]  slave_address;
  logic [3:0]  reg_quantity;
  logic [CW-1:0] byte_count;
  logic [7:0]  pending [2];
  logic [7:0]  header [3];
  logic [7:0]  high_byte_hold;
  logic [3:0]  emit_idx;
  logic [7:0]  run_fail_next;

  crc_ctl_t    crc_ctl;
  logic [15:0] crc_acc;
  logic        crc_busy;

  logic          take;
  logic          take_byte;
  logic          take_end;
  logic [IW-1:0] pos;
  logic [IW-1:0] word_idx;
  logic          ram_we;
  logic          ram_re;
  logic [15:0]   ram_rdata;
  logic          accept;
  logic          emit_last;

  assign busy      = crc_busy || (state == ST_EMIT);
  assign take      = start && !busy;
  assign take_byte = take && !frame_end && (byte_count < CW'(BUFFER_BYTES));
  assign take_end  = take && frame_end;

  assign pos      = IW'(byte_count) - IW'(3);
  assign word_idx = pos >> 1;
  assign ram_we   = take_byte && (byte_count >= CW'(3)) && pos[0] &&
                    (word_idx < IW'(MAX_REGS));
  assign ram_re   = (state == ST_EMIT);
  assign emit_last = (emit_idx == reg_quantity - 4'd1);

  assign crc_ctl.clear = take_end;
  assign crc_ctl.feed  = take_byte && (byte_count >= CW'(2));
  assign crc_ctl.data  = pending[0];

  always_comb begin
    accept = (reg_quantity >= 4'd1) && (32'(reg_quantity) <= RESULT_LIMIT) &&
             (32'(reg_quantity) <= MAX_REGS) &&
             (8'(byte_count) >= 8'(MIN_FRAME)) &&
             (8'(byte_count) >= ({3'b000, reg_quantity, 1'b0} + 8'(MIN_FRAME))) &&
             ({pending[1], pending[0]} == crc_acc) &&
             (header[0] == slave_address) &&
             (header[1] == FUNC_READ) &&
             (header[2] == {3'b000, reg_quantity, 1'b0});
    run_fail_next = (consec_fail == 8'hFF) ? consec_fail : consec_fail + 8'd1;
  end

  mrrc_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .crc  (crc_acc),
    .busy (crc_busy)
  );

  mrrc_ram #(
    .WIDTH (16),
    .DEPTH (MAX_REGS)
  ) u_word_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_idx[RAW-1:0]),
    .wdata ({high_byte_hold, rx_byte}),
    .re    (ram_re),
    .raddr (RAW'(emit_idx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      reg_quantity  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLAVE_ADDR: slave_address <= cfg_data;
        REG_QUANTITY:   reg_quantity  <= cfg_data[3:0];
        default:        ;
      endcase
    end
  end

  // frame assembly
  always_ff @(posedge clk) begin
    if (rst || take_end) begin
      byte_count     <= '0;
      pending[0]     <= '0;
      pending[1]     <= '0;
      header[0]      <= '0;
      header[1]      <= '0;
      header[2]      <= '0;
      high_byte_hold <= '0;
    end else if (take_byte) begin
      if (byte_count >= CW'(2)) begin
        pending[0] <= pending[1];
        pending[1] <= rx_byte;
      end else if (byte_count == CW'(1)) begin
        pending[1] <= rx_byte;
      end else begin
        pending[0] <= rx_byte;
      end
      if (byte_count == CW'(0)) begin
        header[0] <= rx_byte;
      end else if (byte_count == CW'(1)) begin
        header[1] <= rx_byte;
      end else if (byte_count == CW'(2)) begin
        header[2] <= rx_byte;
      end else if (!pos[0]) begin
        high_byte_hold <= rx_byte;
      end
      byte_count <= byte_count + CW'(1);
    end
  end

  // result sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      emit_idx        <= '0;
      done            <= 1'b0;
      frame_ok        <= 1'b0;
      reg_index       <= '0;
      last_of_frame   <= 1'b0;
      ok_total        <= '0;
      fail_total      <= '0;
      consec_fail     <= '0;
      max_consec_fail <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take_end) begin
            if (accept) begin
              ok_total    <= ok_total + 32'd1;
              consec_fail <= '0;
              emit_idx    <= '0;
              state       <= ST_EMIT;
            end else begin
              fail_total    <= fail_total + 32'd1;
              consec_fail   <= run_fail_next;
              if (run_fail_next > max_consec_fail) begin
                max_consec_fail <= run_fail_next;
              end
              done          <= 1'b1;
              frame_ok      <= 1'b0;
              reg_index     <= '0;
              last_of_frame <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          done          <= 1'b1;
          frame_ok      <= 1'b1;
          reg_index     <= emit_idx;
          last_of_frame <= emit_last;
          emit_idx      <= emit_idx + 4'd1;
          if (emit_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign reg_value = frame_ok ? ram_rdata : 16'h0000;

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    done && !frame_ok |-> last_of_frame)
    else $error("failure transfer not marked last");

  a_results_back_to_back: assert property (@(posedge clk) disable iff (rst)
    done && !last_of_frame |=> done && frame_ok)
    else $error("register transfers not contiguous");

  a_no_crc_during_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> !crc_busy && !take)
    else $error("CRC or new item active during result output");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    done && frame_ok |-> reg_index < reg_quantity)
    else $error("register index beyond quantity");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus read-reply checker. Most replies are built
// with a correct CRC-16 trailer and are then sent as they are, padded past
// the buffer, or damaged. They go one byte per transfer, with random gaps unless quiet.
// Every result strobe is compared field by field with a behavioral predictor
// that keeps its own frame state, register file and frame counters.
// ----------------------------------------------------------------------------
module testbench;
  import mrrc_pkg::*;

  localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int WORD_SLOTS   = MAX_REGS_DEF;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_PCT     = 6;
  localparam int RANDOM_ITEMS = 60;
  localparam int SAT_FRAMES   = 258;

  typedef struct packed {
    logic        ok;
    logic [3:0]  idx;
    logic [15:0] val;
    logic        last;
    logic [31:0] ok_cnt;
    logic [31:0] fail_cnt;
    logic [7:0]  run;
    logic [7:0]  peak;
  } reply_t;

  typedef enum int {
    FK_GOOD, FK_OVERLONG, FK_BITFLIP, FK_ADDR, FK_FUNC, FK_COUNT, FK_TRUNC, FK_GARBAGE
  } frame_kind_e;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        done;
  logic        frame_ok;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;
  logic        last_of_frame;
  logic [31:0] ok_total;
  logic [31:0] fail_total;
  logic [7:0]  consec_fail;
  logic [7:0]  max_consec_fail;

  // predictor state
  logic [7:0]  exp_addr;
  logic [3:0]  exp_qty;
  logic [15:0] rx_crc;
  int unsigned rx_count;
  logic [7:0]  rx_tail [2];
  logic [7:0]  rx_hdr [3];
  logic [7:0]  rx_hi;
  logic [15:0] rx_words [WORD_SLOTS];
  logic [31:0] cnt_ok;
  logic [31:0] cnt_fail;
  logic [7:0]  fail_run;
  logic [7:0]  fail_peak;

  reply_t      reply_queue [$];
  logic [7:0]  frame_bytes [$];
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned error_count;
  int unsigned stall_cycles;
  logic        quiet;

  modbus_read_response_checker_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .rx_byte(rx_byte),
    .frame_end(frame_end),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .frame_ok(frame_ok),
    .reg_index(reg_index),
    .reg_value(reg_value),
    .last_of_frame(last_of_frame),
    .ok_total(ok_total),
    .fail_total(fail_total),
    .consec_fail(consec_fail),
    .max_consec_fail(max_consec_fail)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic clear_frame_state();
    rx_crc = CRC_INIT;
    rx_count = 0;
    rx_tail[0] = 8'h00;
    rx_tail[1] = 8'h00;
    rx_hdr[0] = 8'h00;
    rx_hdr[1] = 8'h00;
    rx_hdr[2] = 8'h00;
    rx_hi = 8'h00;
  endtask

  // update the predictor with one transfer and queue the results it causes
  task automatic judge_item(input logic [7:0] b, input logic e);
    int unsigned pos;
    int unsigned q;
    logic        ok;
    reply_t      r;
    if (!e) begin
      if (rx_count < BUF_BYTES) begin
        if (rx_count >= 2) begin
          rx_crc = crc16_byte(rx_crc, rx_tail[0]);
          rx_tail[0] = rx_tail[1];
          rx_tail[1] = b;
        end else begin
          rx_tail[rx_count] = b;
        end
        if (rx_count < 3) begin
          rx_hdr[rx_count] = b;
        end else begin
          pos = rx_count - 3;
          if (pos % 2 == 0) begin
            rx_hi = b;
          end else if ((pos >> 1) < WORD_SLOTS) begin
            rx_words[pos >> 1] = {rx_hi, b};
          end
        end
        rx_count++;
      end
    end else begin
      q = exp_qty;
      ok = q >= 1 && q <= RESULT_LIMIT && q <= WORD_SLOTS &&
           rx_count >= MIN_FRAME && rx_count >= 2 * q + 5;
      if (ok) begin
        ok = {rx_tail[1], rx_tail[0]} == rx_crc && rx_hdr[0] == exp_addr &&
             rx_hdr[1] == FUNC_READ && rx_hdr[2] == 8'(2 * q);
      end
      clear_frame_state();
      if (ok) begin
        cnt_ok++;
        fail_run = 8'h00;
        for (int k = 0; k < q; k++) begin
          r = '{1'b1, 4'(k), rx_words[k], k == q - 1, cnt_ok, cnt_fail, fail_run, fail_peak};
          reply_queue.push_back(r);
        end
      end else begin
        cnt_fail++;
        if (fail_run != 8'hFF) fail_run++;
        if (fail_run > fail_peak) fail_peak = fail_run;
        r = '{1'b0, 4'd0, 16'h0000, 1'b1, cnt_ok, cnt_fail, fail_run, fail_peak};
        reply_queue.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (reply_queue.size() == 0) begin
        report_mismatch("result strobe with nothing expected");
      end else begin
        want = reply_queue.pop_front();
        check_field("frame_ok", frame_ok, want.ok);
        check_field("reg_index", reg_index, want.idx);
        check_field("reg_value", reg_value, want.val);
        check_field("last_of_frame", last_of_frame, want.last);
        check_field("ok_total", ok_total, want.ok_cnt);
        check_field("fail_total", fail_total, want.fail_cnt);
        check_field("consec_fail", consec_fail, want.run);
        check_field("max_consec_fail", max_consec_fail, want.peak);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one transfer; start stays high afterwards until the next item or a drain
  task automatic send_item(input logic [7:0] b, input logic e);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    rx_byte <= b;
    frame_end <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    judge_item(b, e);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (reply_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SLAVE_ADDR) exp_addr = val;
    else exp_qty = val[3:0];
  endtask

  task automatic build_frame(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] cnt, input int unsigned body_len);
    frame_bytes.delete();
    frame_bytes.push_back(addr);
    frame_bytes.push_back(func);
    frame_bytes.push_back(cnt);
    repeat (body_len) frame_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = crc16_byte(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_item(frame_bytes[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic random_frame();
    frame_kind_e kind;
    int unsigned q;
    int unsigned room;
    int unsigned pick;
    int unsigned n;
    q = (exp_qty >= 1 && exp_qty <= RESULT_LIMIT) ? exp_qty : $urandom_range(RESULT_LIMIT, 1);
    room = BUF_BYTES - (2 * q + 5);
    pick = $urandom_range(99);
    if (pick < 60) kind = FK_GOOD;
    else if (pick < 66) kind = FK_OVERLONG;
    else if (pick < 72) kind = FK_BITFLIP;
    else if (pick < 78) kind = FK_ADDR;
    else if (pick < 83) kind = FK_FUNC;
    else if (pick < 88) kind = FK_COUNT;
    else if (pick < 94) kind = FK_TRUNC;
    else kind = FK_GARBAGE;
    case (kind)
      FK_GOOD: begin
        n = ($urandom_range(3) == 0) ? $urandom_range(room) : 0;
        build_frame(exp_addr, FUNC_READ, 8'(2 * q), 2 * q + n);
        seal_frame();
      end
      FK_OVERLONG: begin
        // fills the buffer exactly, the tail beyond it must be dropped
        build_frame(exp_addr, FUNC_READ, 8'(2 * q), 2 * q + room);
        seal_frame();
        repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255)));
      end
      FK_BITFLIP: begin
        build_frame(exp_addr, FUNC_READ, 8'(2 * q), 2 * q);
        seal_frame();
        n = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[n] = frame_bytes[n] ^ (8'h01 << $urandom_range(7));
      end
      FK_ADDR: begin
        build_frame(exp_addr ^ 8'($urandom_range(255, 1)), FUNC_READ, 8'(2 * q), 2 * q);
        seal_frame();
      end
      FK_FUNC: begin
        build_frame(exp_addr, FUNC_READ ^ 8'($urandom_range(255, 1)), 8'(2 * q), 2 * q);
        seal_frame();
      end
      FK_COUNT: begin
        build_frame(exp_addr, FUNC_READ, 8'(2 * q) ^ 8'($urandom_range(255, 1)), 2 * q);
        seal_frame();
      end
      FK_TRUNC: begin
        build_frame(exp_addr, FUNC_READ, 8'(2 * q), 2 * q);
        seal_frame();
        repeat ($urandom_range(frame_bytes.size(), 1)) void'(frame_bytes.pop_back());
      end
      default: begin
        frame_bytes.delete();
        repeat ($urandom_range(40)) frame_bytes.push_back(8'($urandom_range(255)));
      end
    endcase
    send_frame();
  endtask

  task automatic test_default_config();
    // reset setting: address 1, one register, value all ones
    build_frame(8'd1, FUNC_READ, 8'd2, 2);
    frame_bytes[3] = 8'hFF;
    frame_bytes[4] = 8'hFF;
    seal_frame();
    send_frame();
    drain();
  endtask

  task automatic test_short_frames();
    send_item(8'($urandom_range(255)), 1'b1);
    build_frame(8'd1, FUNC_READ, 8'd2, 1);
    send_frame();
    drain();
  endtask

  task automatic test_quantity_limits();
    // zero registers: minimal five-byte reply is still rejected
    write_cfg(REG_QUANTITY, 8'h00);
    build_frame(8'd1, FUNC_READ, 8'd0, 0);
    seal_frame();
    send_frame();
    drain();
    write_cfg(REG_QUANTITY, 8'hFE);
    send_item(8'h00, 1'b1);
    drain();
    write_cfg(REG_QUANTITY, 8'hFF);
    send_item(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_fail_run_saturation();
    write_cfg(REG_SLAVE_ADDR, 8'($urandom_range(247)));
    write_cfg(REG_QUANTITY, 8'd2);
    // empty frames back to back, no idle gaps
    quiet = 1'b1;
    repeat (SAT_FRAMES) send_item(8'($urandom_range(255)), 1'b1);
    quiet = 1'b0;
    build_frame(exp_addr, FUNC_READ, 8'd4, 4);
    seal_frame();
    send_frame();
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned first_item;
    int unsigned phase;
    first_item = items_sent;
    phase = 0;
    while (phase < 3 || items_sent - first_item < RANDOM_ITEMS) begin
      drain();
      case (phase)
        0: begin
          write_cfg(REG_SLAVE_ADDR, 8'd247);
          write_cfg(REG_QUANTITY, 8'(RESULT_LIMIT));
        end
        1: begin
          write_cfg(REG_SLAVE_ADDR, 8'd0);
          write_cfg(REG_QUANTITY, 8'd1);
        end
        default: begin
          write_cfg(REG_SLAVE_ADDR, 8'($urandom_range(247)));
          if ($urandom_range(9) == 0) write_cfg(REG_QUANTITY, 8'($urandom_range(255)));
          else write_cfg(REG_QUANTITY, 8'($urandom_range(6, 1)));
        end
      endcase
      quiet = (phase == 2);
      repeat (2) random_frame();
      phase++;
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    rx_byte = 8'h00;
    frame_end = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SLAVE_ADDR;
    cfg_data = 8'h00;
    quiet = 1'b0;
    items_sent = 0;
    results_checked = 0;
    error_count = 0;
    stall_cycles = 0;
    exp_addr = 8'd1;
    exp_qty = 4'd1;
    clear_frame_state();
    foreach (rx_words[i]) rx_words[i] = 16'h0000;
    cnt_ok = 32'd0;
    cnt_fail = 32'd0;
    fail_run = 8'd0;
    fail_peak = 8'd0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_default_config();
    test_short_frames();
    test_quantity_limits();
    test_fail_run_saturation();
    test_random_traffic();

    $display("covered %0d transfers, %0d replies accepted, %0d rejected, %0d results checked",
             items_sent, cnt_ok, cnt_fail, results_checked);
    $display("longest rejection run %0d, mismatches %0d", fail_peak, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
